@@ src/nearest_vertex_search_unit_assert.svh @@
// ----------------------------------------------------------------------------
// nearest_vertex_search_unit assertion macros
// Shared concurrent assertion forms for the search unit modules.
// ----------------------------------------------------------------------------
`ifndef NEAREST_VERTEX_SEARCH_UNIT_ASSERT_SVH
`define NEAREST_VERTEX_SEARCH_UNIT_ASSERT_SVH

// same-cycle implication, checked out of reset
`define NVS_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("nvs assertion failed");

// next-cycle implication, checked out of reset
`define NVS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("nvs assertion failed");

`endif

@@ src/nvs_pkg.sv @@
// ----------------------------------------------------------------------------
// nvs_pkg
// Widths, command codes and controller/datapath link types.
// ----------------------------------------------------------------------------
package nvs_pkg;

  localparam int MAX_VERTICES = 1024;
  localparam int IDX_W        = 10;
  localparam int CNT_W        = 11;
  localparam int COORD_W      = 20;
  localparam int DIFF_W       = COORD_W + 1;
  localparam int SQ_W         = 2 * COORD_W + 1;
  localparam int SUM_W        = SQ_W + 1;
  localparam int DIST_W       = SUM_W / 2;
  localparam int SQRT_CNT_W   = 5;

  typedef logic [IDX_W-1:0]          index_t;
  typedef logic [CNT_W-1:0]          count_t;
  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic signed [DIFF_W-1:0]  diff_t;
  typedef logic [SQ_W-1:0]           square_t;
  typedef logic [SUM_W-1:0]          sum_t;
  typedef logic [DIST_W-1:0]         dist_t;

  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  localparam count_t MAX_COUNT = count_t'(MAX_VERTICES);

  typedef struct packed {
    logic   mem_wr;
    logic   rd_en;
    index_t rd_addr;
    logic   latch_query;
    logic   clear_best;
    logic   sqrt_start;
    logic   load_out;
  } ctrl_cmd_t;

  typedef struct packed {
    logic pipe_busy;
    logic sqrt_busy;
    logic out_full;
  } dp_status_t;

endpackage

@@ src/nvs_in_if.sv @@
// ----------------------------------------------------------------------------
// nvs_in_if
// Input channel: load or query transactions with a point.
// ----------------------------------------------------------------------------
interface nvs_in_if;
  import nvs_pkg::*;

  logic   valid;
  logic   ready;
  logic   command;
  index_t vertex_index;
  coord_t coord_x;
  coord_t coord_y;
  coord_t coord_z;

  modport source (output valid, command, vertex_index, coord_x, coord_y, coord_z,
                  input ready);
  modport sink   (input valid, command, vertex_index, coord_x, coord_y, coord_z,
                  output ready);
endinterface

@@ src/nvs_out_if.sv @@
// ----------------------------------------------------------------------------
// nvs_out_if
// Result channel: nearest vertex index and distance.
// ----------------------------------------------------------------------------
interface nvs_out_if;
  import nvs_pkg::*;

  logic   valid;
  logic   ready;
  logic   found;
  index_t nearest_index;
  dist_t  distance;

  modport source (output valid, found, nearest_index, distance, input ready);
  modport sink   (input valid, found, nearest_index, distance, output ready);
endinterface

@@ src/nvs_sqrt.sv @@
// ----------------------------------------------------------------------------
// nvs_sqrt
// Integer square root, one result bit per cycle (digit-by-digit).
// ----------------------------------------------------------------------------
module nvs_sqrt (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  nvs_pkg::sum_t radicand,
  output logic          busy,
  output nvs_pkg::dist_t root
);
  import nvs_pkg::*;

  localparam logic [SQRT_CNT_W-1:0] LAST_STEP = SQRT_CNT_W'(DIST_W - 1);

  sum_t                  rad_r;
  logic [DIST_W:0]       rem_r;
  dist_t                 root_r;
  logic [SQRT_CNT_W-1:0] cnt_r;
  logic                  busy_r;

  logic [DIST_W+2:0] rem_sh;
  logic [DIST_W+2:0] trial;
  logic [DIST_W+2:0] rem_sub;
  logic              take;

  assign rem_sh  = {rem_r, rad_r[SUM_W-1 -: 2]};
  assign trial   = {1'b0, root_r, 2'b01};
  assign take    = rem_sh >= trial;
  assign rem_sub = rem_sh - trial;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else if (start) begin
      busy_r <= 1'b1;
    end else if (busy_r && cnt_r == LAST_STEP) begin
      busy_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rad_r  <= radicand;
      rem_r  <= '0;
      root_r <= '0;
      cnt_r  <= '0;
    end else if (busy_r) begin
      rad_r  <= {rad_r[SUM_W-3:0], 2'b00};
      rem_r  <= take ? rem_sub[DIST_W:0] : rem_sh[DIST_W:0];
      root_r <= {root_r[DIST_W-2:0], take};
      cnt_r  <= cnt_r + 1'b1;
    end
  end

  assign busy = busy_r;
  assign root = root_r;
endmodule

@@ src/nvs_datapath.sv @@
// ----------------------------------------------------------------------------
// nvs_datapath
// Vertex memory, distance pipeline, running minimum, root unit, result reg.
// ----------------------------------------------------------------------------
`include "nearest_vertex_search_unit_assert.svh"

module nvs_datapath (
  input  logic               clk,
  input  logic               rst_n,
  input  nvs_pkg::ctrl_cmd_t cmd,
  output nvs_pkg::dp_status_t status,
  input  nvs_pkg::index_t    in_vertex_index,
  input  nvs_pkg::coord_t    in_coord_x,
  input  nvs_pkg::coord_t    in_coord_y,
  input  nvs_pkg::coord_t    in_coord_z,
  input  logic               out_ready,
  output logic               out_valid,
  output logic               out_found,
  output nvs_pkg::index_t    out_nearest_index,
  output nvs_pkg::dist_t     out_distance
);
  import nvs_pkg::*;

  // vertex table: {x, y, z}
  logic [3*COORD_W-1:0] mem [MAX_VERTICES];
  logic [3*COORD_W-1:0] rd_data_r;

  coord_t  qx_r, qy_r, qz_r;
  logic    va_r, vb_r, vc_r, vd_r;
  index_t  ia_r, ib_r, ic_r, id_r;
  diff_t   dx_r, dy_r, dz_r;
  square_t sx_r, sy_r, sz_r;
  sum_t    sum_r;

  logic    have_r;
  index_t  best_i_r;
  sum_t    best_d_r;

  logic    out_valid_r;
  logic    found_r;
  index_t  index_r;
  dist_t   dist_r;

  coord_t  mx, my, mz;
  logic signed [2*DIFF_W-1:0] px, py, pz;
  dist_t   root;
  logic    sqrt_busy;

  always_ff @(posedge clk) begin
    if (cmd.mem_wr) begin
      mem[in_vertex_index] <= {in_coord_x, in_coord_y, in_coord_z};
    end
    if (cmd.rd_en) begin
      rd_data_r <= mem[cmd.rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch_query) begin
      qx_r <= in_coord_x;
      qy_r <= in_coord_y;
      qz_r <= in_coord_z;
    end
  end

  assign mx = rd_data_r[3*COORD_W-1 -: COORD_W];
  assign my = rd_data_r[2*COORD_W-1 -: COORD_W];
  assign mz = rd_data_r[COORD_W-1:0];

  assign px = dx_r * dx_r;
  assign py = dy_r * dy_r;
  assign pz = dz_r * dz_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vb_r <= 1'b0;
      vc_r <= 1'b0;
      vd_r <= 1'b0;
    end else begin
      va_r <= cmd.rd_en;
      vb_r <= va_r;
      vc_r <= vb_r;
      vd_r <= vc_r;
    end
  end

  always_ff @(posedge clk) begin
    ia_r  <= cmd.rd_addr;
    ib_r  <= ia_r;
    ic_r  <= ib_r;
    id_r  <= ic_r;
    dx_r  <= diff_t'(mx) - diff_t'(qx_r);
    dy_r  <= diff_t'(my) - diff_t'(qy_r);
    dz_r  <= diff_t'(mz) - diff_t'(qz_r);
    sx_r  <= px[SQ_W-1:0];
    sy_r  <= py[SQ_W-1:0];
    sz_r  <= pz[SQ_W-1:0];
    sum_r <= sum_t'(sx_r) + sum_t'(sy_r) + sum_t'(sz_r);
  end

  // strict less-than keeps the lower index on a tie
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      have_r   <= 1'b0;
      best_i_r <= '0;
    end else if (cmd.clear_best) begin
      have_r   <= 1'b0;
      best_i_r <= '0;
    end else if (vd_r && (!have_r || sum_r < best_d_r)) begin
      have_r   <= 1'b1;
      best_i_r <= id_r;
    end
  end

  always_ff @(posedge clk) begin
    if (vd_r && (!have_r || sum_r < best_d_r)) begin
      best_d_r <= sum_r;
    end
  end

  nvs_sqrt u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.sqrt_start),
    .radicand (best_d_r),
    .busy     (sqrt_busy),
    .root     (root)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      found_r <= have_r;
      index_r <= have_r ? best_i_r : '0;
      dist_r  <= have_r ? root : '0;
    end
  end

  assign status.pipe_busy = va_r | vb_r | vc_r | vd_r;
  assign status.sqrt_busy = sqrt_busy;
  assign status.out_full  = out_valid_r & ~out_ready;

  assign out_valid         = out_valid_r;
  assign out_found         = found_r;
  assign out_nearest_index = index_r;
  assign out_distance      = dist_r;

  `NVS_ASSERT_NOW(a_empty_zero, out_valid_r && !found_r, index_r == '0 && dist_r == '0)
  `NVS_ASSERT_NEXT(a_sqrt_runs, cmd.sqrt_start, sqrt_busy)

endmodule

@@ src/nvs_ctrl.sv @@
// ----------------------------------------------------------------------------
// nvs_ctrl
// Sequencer: load write, table scan, pipeline drain, root, result handoff.
// ----------------------------------------------------------------------------
`include "nearest_vertex_search_unit_assert.svh"

module nvs_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_command,
  output logic                in_ready,
  input  logic                cfg_we,
  input  nvs_pkg::count_t     cfg_wdata,
  input  nvs_pkg::dp_status_t status,
  output nvs_pkg::ctrl_cmd_t  cmd
);
  import nvs_pkg::*;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_SCAN  = 3'd1;
  localparam logic [2:0] ST_DRAIN = 3'd2;
  localparam logic [2:0] ST_SQRT  = 3'd3;
  localparam logic [2:0] ST_FIN   = 3'd4;

  logic [2:0] state_r, state_nxt;
  count_t     vcount_r;
  count_t     n_r, n_nxt;
  index_t     cnt_r, cnt_nxt;
  count_t     clamped;
  logic       accept;

  assign clamped = (vcount_r > MAX_COUNT) ? MAX_COUNT : vcount_r;
  assign in_ready = (state_r == ST_IDLE);
  assign accept   = in_valid && in_ready;

  always_comb begin
    state_nxt       = state_r;
    n_nxt           = n_r;
    cnt_nxt         = cnt_r;
    cmd             = '0;
    cmd.rd_addr     = cnt_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (in_command == CMD_LOAD) begin
            cmd.mem_wr = 1'b1;
          end else begin
            cmd.latch_query = 1'b1;
            cmd.clear_best  = 1'b1;
            n_nxt           = clamped;
            cnt_nxt         = '0;
            state_nxt       = (clamped == '0) ? ST_FIN : ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        cmd.rd_en = 1'b1;
        cnt_nxt   = cnt_r + 1'b1;
        if (count_t'(cnt_r) + 1'b1 == n_r) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!status.pipe_busy) begin
          cmd.sqrt_start = 1'b1;
          state_nxt      = ST_SQRT;
        end
      end
      ST_SQRT: begin
        if (!status.sqrt_busy) begin
          state_nxt = ST_FIN;
        end
      end
      ST_FIN: begin
        // hold until the result register is free
        if (!status.out_full) begin
          cmd.load_out = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      vcount_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        vcount_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    n_r   <= n_nxt;
    cnt_r <= cnt_nxt;
  end

  `NVS_ASSERT_NOW(a_scan_in_range, state_r == ST_SCAN, count_t'(cnt_r) < n_r)
  `NVS_ASSERT_NOW(a_root_after_drain, cmd.sqrt_start, !status.pipe_busy)
  `NVS_ASSERT_NOW(a_out_when_free, cmd.load_out, !status.out_full && state_r == ST_FIN)

endmodule

@@ src/nearest_vertex_search_unit.sv @@
// ----------------------------------------------------------------------------
// nearest_vertex_search_unit
// Nearest of a table of 3D Q10.10 points to a query point, with distance.
//
//   channel  dir  handshake       payload
//   in_chan  in   valid/ready     command, vertex_index, coord_x/y/z
//   out_chan out  valid/ready     found, nearest_index, distance
//   cfg      in   cfg_we          cfg_wdata = vertex_count
//
// A load writes its table entry on acceptance. A query runs from its
// transaction to its result through n memory reads of scan, n being
// vertex_count clamped to the table size, at one memory read per cycle, a
// drain of the four-stage distance pipeline, the bit-serial root (21 steps)
// and a load of the result register. An empty scan skips drain and root.
// Reset clears control state and vertex_count; table contents are unset.
// A result waiting on out_chan does not stop loads; a query finishing behind
// it holds until that transaction is taken.
// ----------------------------------------------------------------------------
module nearest_vertex_search_unit (
  input  logic            clk,
  input  logic            rst_n,
  nvs_in_if.sink          in_chan,
  nvs_out_if.source       out_chan,
  input  logic            cfg_we,
  input  nvs_pkg::count_t cfg_wdata
);
  import nvs_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t status;

  nvs_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_chan.valid),
    .in_command (in_chan.command),
    .in_ready   (in_chan.ready),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .status     (status),
    .cmd        (cmd)
  );

  nvs_datapath u_datapath (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .status            (status),
    .in_vertex_index   (in_chan.vertex_index),
    .in_coord_x        (in_chan.coord_x),
    .in_coord_y        (in_chan.coord_y),
    .in_coord_z        (in_chan.coord_z),
    .out_ready         (out_chan.ready),
    .out_valid         (out_chan.valid),
    .out_found         (out_chan.found),
    .out_nearest_index (out_chan.nearest_index),
    .out_distance      (out_chan.distance)
  );

endmodule

@@ tb/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench for nearest_vertex_search_unit
// Loads vertex tables and issues nearest-point queries over the valid/ready
// channels. Expected results come from a behavioral search held in this
// bench and are checked in order against every result transaction. Covers
// the empty scan, ties, extreme coordinates, random traffic with bursty
// idling on both sides and a long result stall.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import nvs_pkg::*;

  localparam int     WATCHDOG_LIMIT = 20000;
  localparam int     SETTLE_CYCLES  = 40;
  localparam int     PRESSURE_HOLD  = 600;
  localparam coord_t COORD_MIN      = coord_t'(20'h80000);
  localparam coord_t COORD_MAX      = coord_t'(20'h7FFFF);

  typedef struct packed {
    logic   found;
    index_t nearest_index;
    dist_t  distance;
  } nearest_result_t;

  logic   clk;
  logic   rst_n;
  logic   cfg_we;
  count_t cfg_wdata;

  nvs_in_if  in_chan ();
  nvs_out_if out_chan ();

  nearest_vertex_search_unit DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_chan   (in_chan),
    .out_chan  (out_chan),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  // bench copy of the vertex table and the scan length
  coord_t vtx_x [MAX_VERTICES];
  coord_t vtx_y [MAX_VERTICES];
  coord_t vtx_z [MAX_VERTICES];
  bit     vtx_written [MAX_VERTICES];
  count_t scan_count = '0;

  nearest_result_t pending_results [$];

  int fail_count        = 0;
  int idle_cycles       = 0;
  int pressure_requests = 0;
  int pressure_served   = 0;
  bit idle_on           = 1'b1;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic dist_t floor_root(longint unsigned v);
    longint unsigned root;
    longint unsigned trial;
    root = 0;
    for (int b = DIST_W - 1; b >= 0; b--) begin
      trial = root | (64'd1 << b);
      if (trial * trial <= v) root = trial;
    end
    return dist_t'(root);
  endfunction

  function automatic nearest_result_t find_nearest(coord_t qx, coord_t qy, coord_t qz);
    nearest_result_t r;
    longint          best_sq;
    longint          sq;
    longint          dx;
    longint          dy;
    longint          dz;
    int              limit;
    r = '0;
    best_sq = 0;
    limit = (scan_count > MAX_COUNT) ? MAX_VERTICES : int'(scan_count);
    for (int i = 0; i < limit; i++) begin
      dx = longint'(vtx_x[i]) - longint'(qx);
      dy = longint'(vtx_y[i]) - longint'(qy);
      dz = longint'(vtx_z[i]) - longint'(qz);
      sq = dx * dx + dy * dy + dz * dz;
      // strict compare keeps the lower index on a tie
      if (!r.found || sq < best_sq) begin
        r.found = 1'b1;
        r.nearest_index = index_t'(i);
        best_sq = sq;
      end
    end
    if (r.found) r.distance = floor_root(unsigned'(best_sq));
    return r;
  endfunction

  function automatic coord_t rand_coord();
    case ($urandom_range(0, 5))
      0: return COORD_MIN;
      1: return COORD_MAX;
      2, 3: return coord_t'(int'($urandom_range(0, 4000)) - 2000);
      default: return coord_t'($urandom);
    endcase
  endfunction

  // Leaves valid high after the accepting edge; the next call or
  // wait_idle decides what the input carries next.
  task automatic send_item(logic cmd, index_t idx, coord_t x, coord_t y, coord_t z);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_chan.valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    in_chan.valid        <= 1'b1;
    in_chan.command      <= cmd;
    in_chan.vertex_index <= idx;
    in_chan.coord_x      <= x;
    in_chan.coord_y      <= y;
    in_chan.coord_z      <= z;
    do @(posedge clk); while (!in_chan.ready);
    if (cmd == CMD_LOAD) begin
      vtx_x[idx] = x;
      vtx_y[idx] = y;
      vtx_z[idx] = z;
      vtx_written[idx] = 1'b1;
    end else begin
      pending_results = {pending_results, find_nearest(x, y, z)};
    end
  endtask

  task automatic send_query(coord_t x, coord_t y, coord_t z);
    send_item(CMD_QUERY, index_t'($urandom), x, y, z);
  endtask

  task automatic wait_idle();
    in_chan.valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_vertex_count(int n);
    cfg_we    <= 1'b1;
    cfg_wdata <= count_t'(n);
    @(posedge clk);
    cfg_we     <= 1'b0;
    scan_count = count_t'(n);
    @(posedge clk);
  endtask

  // write every slot a scan of n entries will touch
  task automatic load_prefix(int n);
    for (int i = 0; i < n && i < MAX_VERTICES; i++) begin
      if (!vtx_written[i]) send_item(CMD_LOAD, index_t'(i), rand_coord(), rand_coord(),
                                     rand_coord());
    end
  endtask

  task automatic test_empty_table();
    // count is still at its reset value here
    send_query(COORD_MAX, COORD_MIN, coord_t'(0));
    wait_idle();
    set_vertex_count(0);
    send_query(COORD_MIN, COORD_MIN, COORD_MIN);
    send_query(coord_t'(0), coord_t'(0), coord_t'(0));
    wait_idle();
  endtask

  task automatic test_extremes_and_ties();
    send_item(CMD_LOAD, index_t'(0), COORD_MIN, COORD_MIN, COORD_MIN);
    wait_idle();
    set_vertex_count(1);
    send_query(COORD_MAX, COORD_MAX, COORD_MAX);
    send_query(COORD_MIN, COORD_MIN, COORD_MIN);
    send_query(coord_t'(20'h55555), coord_t'(20'hAAAAA), coord_t'(20'h55555));
    send_item(CMD_LOAD, index_t'(1), COORD_MAX, COORD_MAX, COORD_MAX);
    send_item(CMD_LOAD, index_t'(2), coord_t'(0), coord_t'(0), coord_t'(0));
    send_item(CMD_LOAD, index_t'(3), COORD_MAX, COORD_MAX, COORD_MAX);
    send_item(CMD_LOAD, index_t'(1023), COORD_MAX, COORD_MIN, coord_t'(0));
    send_item(CMD_LOAD, index_t'(512), coord_t'(20'hAAAAA), coord_t'(20'h55555),
              coord_t'(20'hAAAAA));
    wait_idle();
    set_vertex_count(4);
    send_query(COORD_MAX, COORD_MAX, COORD_MAX);
    send_query(coord_t'(1), coord_t'(0), coord_t'(-1));
    send_query(COORD_MIN, COORD_MAX, coord_t'(0));
    send_query(COORD_MAX, COORD_MIN, COORD_MAX);
    send_query(coord_t'(20'hAAAAA), coord_t'(20'h55555), coord_t'(20'hAAAAA));
    wait_idle();
  endtask

  task automatic test_random_traffic(int phases);
    int     n;
    int     j;
    int     kind;
    coord_t dx;
    for (int p = 0; p < phases; p++) begin
      n = ($urandom_range(0, 7) == 0) ? $urandom_range(49, 160) : $urandom_range(1, 48);
      load_prefix(n);
      wait_idle();
      set_vertex_count(n);
      repeat (40) begin
        kind = $urandom_range(0, 9);
        j = $urandom_range(0, n - 1);
        dx = coord_t'(int'($urandom_range(0, 64)) - 32);
        case (kind)
          0, 1: send_item(CMD_LOAD, index_t'($urandom), rand_coord(), rand_coord(),
                          rand_coord());
          // duplicate an entry to set up ties
          2: send_item(CMD_LOAD, index_t'($urandom_range(0, n - 1)), vtx_x[j], vtx_y[j],
                       vtx_z[j]);
          3, 4, 5: send_query(vtx_x[j] + dx, vtx_y[j] - dx, vtx_z[j] + coord_t'(kind));
          6: send_query(vtx_x[j], vtx_y[j], vtx_z[j]);
          default: send_query(rand_coord(), rand_coord(), rand_coord());
        endcase
      end
      wait_idle();
    end
  endtask

  task automatic test_result_backpressure();
    load_prefix(8);
    wait_idle();
    set_vertex_count(8);
    pressure_requests++;
    repeat (12) send_query(rand_coord(), rand_coord(), rand_coord());
    wait_idle();
  endtask

  initial begin
    rst_n                <= 1'b0;
    cfg_we               <= 1'b0;
    cfg_wdata            <= '0;
    in_chan.valid        <= 1'b0;
    in_chan.command      <= CMD_LOAD;
    in_chan.vertex_index <= '0;
    in_chan.coord_x      <= '0;
    in_chan.coord_y      <= '0;
    in_chan.coord_z      <= '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_empty_table();
    test_extremes_and_ties();
    test_random_traffic(9);
    test_result_backpressure();
    idle_on = 1'b0;
    test_random_traffic(2);

    if (fail_count == 0) begin
      $display("nearest_vertex_search_unit test passed");
    end else begin
      $display("nearest_vertex_search_unit test failed");
    end
    $finish;
  end

  // result sink: random stalls, plus one long hold on request
  initial begin
    out_chan.ready <= 1'b0;
    wait (rst_n);
    @(posedge clk);
    forever begin
      if (pressure_served != pressure_requests) begin
        out_chan.ready <= 1'b0;
        repeat (PRESSURE_HOLD) @(posedge clk);
        pressure_served++;
      end else if (idle_on && $urandom_range(0, 4) == 0) begin
        out_chan.ready <= 1'b0;
        repeat ($urandom_range(1, 5)) @(posedge clk);
      end else begin
        out_chan.ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin : check_results
    nearest_result_t want;
    if (rst_n && out_chan.valid && out_chan.ready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result transaction found=%0d index=%0d distance=%0d",
                 $time, out_chan.found, out_chan.nearest_index, out_chan.distance);
        fail_count++;
      end else begin
        want = pending_results.pop_front();
        if (out_chan.found !== want.found) begin
          $display("%0t: found mismatch expected %0d actual %0d", $time, want.found,
                   out_chan.found);
          fail_count++;
        end
        if (out_chan.nearest_index !== want.nearest_index) begin
          $display("%0t: nearest_index mismatch expected %0d actual %0d", $time,
                   want.nearest_index, out_chan.nearest_index);
          fail_count++;
        end
        if (out_chan.distance !== want.distance) begin
          $display("%0t: distance mismatch expected %0d actual %0d", $time,
                   want.distance, out_chan.distance);
          fail_count++;
        end
      end
    end
  end

  // end the run when no transaction moves for too long
  always @(posedge clk) begin
    if (!rst_n || (in_chan.valid && in_chan.ready) || (out_chan.valid && out_chan.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no transaction for %0d cycles", $time, idle_cycles);
      $display("nearest_vertex_search_unit test failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule

@@ filelist.f @@
+incdir+src
src/nvs_pkg.sv
src/nvs_in_if.sv
src/nvs_out_if.sv
src/nvs_sqrt.sv
src/nvs_datapath.sv
src/nvs_ctrl.sv
src/nearest_vertex_search_unit.sv
tb/testbench.sv
